### design/erpm_pkg.sv
// Shared types and constants for the edge run peak marker.
`timescale 1ns / 1ps
package erpm_pkg;

  // Field widths fixed by the interface
  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int MASK_W  = 3;
  localparam int THR_W   = 8;
  localparam int DIST_W  = 7;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE  = 1'd1;

  // Channel masks: bit0 red, bit1 green, bit2 blue
  localparam logic [MASK_W-1:0] MASK_CLEAR_POS = 3'd5;
  localparam logic [MASK_W-1:0] MASK_CLEAR_NEG = 3'd6;
  localparam logic [MASK_W-1:0] MASK_PAINT     = 3'd7;

  localparam logic [PIX_W-1:0] VAL_FULL = 8'hFF;
  localparam logic [PIX_W-1:0] VAL_ZERO = 8'h00;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Commands that one pixel can cause
  localparam int SLOTS = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_row;
    logic             end_of_frame;
  } pix_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] write_x;
    logic [COORD_W-1:0] write_y;
    logic [MASK_W-1:0]  channel_mask;
    logic [PIX_W-1:0]   red_value;
    logic [PIX_W-1:0]   green_value;
    logic [PIX_W-1:0]   blue_value;
    logic               last_write;
  } cmd_req_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic               cmp;      // comparison made for this pixel
    logic               pos;      // positive difference above threshold
    logic               neg;      // negative difference above threshold
    logic [PIX_W-1:0]   mag;      // magnitude of the difference that hit
    logic [COORD_W-1:0] x;        // current column
    logic [COORD_W-1:0] xd;       // column of the left-hand pixel
    logic [COORD_W-1:0] y;
    logic               row_end;
  } cls_t;

endpackage

### design/edge_run_peak_marker.sv
// Top level: configuration registers, front end, queue and back end.
// A pixel passes the front stage register, queue and output register before its first
// write command. Throughput: one pixel per cycle while each causes at most one write and
// cmd_ready is high; the back end issues one write command per cycle when cmd_ready allows.
// Reset (rst, synchronous): clears coordinates, runs, queue and handshakes;
// threshold returns to 0 and pixel_distance to 1; the delay ring is not cleared.
`timescale 1ns / 1ps
module edge_run_peak_marker #(
  parameter int MAX_DISTANCE = 64,
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  erpm_pkg::pix_req_t              pix_req,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output erpm_pkg::cmd_req_t              cmd_req,
  input  logic                            cfg_we,
  input  logic [erpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erpm_pkg::CFG_W-1:0]      cfg_data
);

  logic [erpm_pkg::THR_W-1:0]  threshold;
  logic [erpm_pkg::DIST_W-1:0] pixel_distance;

  logic           f_valid;
  logic           f_ready;
  erpm_pkg::cls_t f_data;
  logic           q_valid;
  logic           q_ready;
  erpm_pkg::cls_t q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      pixel_distance <= erpm_pkg::DIST_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        erpm_pkg::REG_THRESHOLD: threshold      <= cfg_data[erpm_pkg::THR_W-1:0];
        erpm_pkg::REG_DISTANCE:  pixel_distance <= cfg_data[erpm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  erpm_front #(
    .MAX_DISTANCE (MAX_DISTANCE),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .pix_req        (pix_req),
    .threshold      (threshold),
    .pixel_distance (pixel_distance),
    .cls_valid      (f_valid),
    .cls_ready      (f_ready),
    .cls_data       (f_data)
  );

  erpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  erpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_req   (cmd_req)
  );

endmodule

### design/erpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module erpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the slot being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/erpm_front.sv
// Front end: accepts pixels, keeps coordinates and the delay ring, classifies differences.
`timescale 1ns / 1ps
module erpm_front #(
  parameter int MAX_DISTANCE = 64,
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  erpm_pkg::pix_req_t           pix_req,
  input  logic [erpm_pkg::THR_W-1:0]   threshold,
  input  logic [erpm_pkg::DIST_W-1:0]  pixel_distance,
  output logic                         cls_valid,
  input  logic                         cls_ready,
  output erpm_pkg::cls_t               cls_data
);

  localparam int PW   = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;
  localparam int DW   = $clog2(MAX_DISTANCE + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CMPW = (CW > DW) ? CW : DW;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] wp;

  // Stage register between the ring read and classification
  logic                         s1_valid;
  logic [erpm_pkg::PIX_W-1:0]   s1_pix;
  logic                         s1_cmp;
  logic [erpm_pkg::COORD_W-1:0] s1_x;
  logic [erpm_pkg::COORD_W-1:0] s1_xd;
  logic [erpm_pkg::COORD_W-1:0] s1_y;
  logic                         s1_end;

  logic                         accept;
  logic [DW-1:0]                eff_dist;
  logic [PW:0]                  wp_ext;
  logic [PW:0]                  dist_ext;
  logic [PW-1:0]                raddr;
  logic [CMPW-1:0]              col_ext;
  logic [CMPW-1:0]              dist_cmp;
  logic [erpm_pkg::PIX_W-1:0]   old_pix;
  logic [erpm_pkg::PIX_W:0]     dif;
  logic [erpm_pkg::PIX_W:0]     ndif;
  logic                         pos;
  logic                         neg;

  assign accept    = pix_valid && pix_ready;
  assign pix_ready = !s1_valid || cls_ready;

  // Effective distance: zero acts as one, clamp at the ring depth
  always_comb begin
    if (pixel_distance == '0) begin
      eff_dist = DW'(1);
    end else if (32'(pixel_distance) > MAX_DISTANCE) begin
      eff_dist = DW'(MAX_DISTANCE);
    end else begin
      eff_dist = DW'(pixel_distance);
    end
  end

  // Ring slot written eff_dist requests ago
  assign wp_ext   = (PW + 1)'(wp);
  assign dist_ext = (PW + 1)'(eff_dist);
  always_comb begin
    if (wp_ext >= dist_ext) begin
      raddr = PW'(wp_ext - dist_ext);
    end else begin
      raddr = PW'(wp_ext + (PW + 1)'(MAX_DISTANCE) - dist_ext);
    end
  end

  assign col_ext  = CMPW'(col);
  assign dist_cmp = CMPW'(eff_dist);

  erpm_ram #(
    .WIDTH (erpm_pkg::PIX_W),
    .DEPTH (MAX_DISTANCE),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (pix_req.pixel),
    .re    (accept),
    .raddr (raddr),
    .rdata (old_pix)
  );

  // Coordinates and ring pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      wp  <= '0;
    end else if (accept) begin
      wp <= (wp == PW'(MAX_DISTANCE - 1)) ? '0 : wp + 1'b1;
      if (pix_req.end_of_row || pix_req.end_of_frame) begin
        col <= '0;
        if (pix_req.end_of_frame) begin
          row <= '0;
        end else if (row < RW'(MAX_HEIGHT - 1)) begin
          row <= row + 1'b1;
        end
      end else if (col < CW'(MAX_WIDTH - 1)) begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix_req.pixel;
      s1_cmp <= col_ext >= dist_cmp;
      s1_x   <= erpm_pkg::COORD_W'(col);
      s1_xd  <= erpm_pkg::COORD_W'(col_ext - dist_cmp);
      s1_y   <= erpm_pkg::COORD_W'(row);
      s1_end <= pix_req.end_of_row || pix_req.end_of_frame;
    end
  end

  // Classify: dif = left pixel minus current pixel
  assign dif  = {1'b0, old_pix} - {1'b0, s1_pix};
  assign ndif = {1'b0, s1_pix} - {1'b0, old_pix};
  assign pos  = s1_cmp && !dif[erpm_pkg::PIX_W] && (dif[erpm_pkg::PIX_W-1:0] > threshold);
  assign neg  = s1_cmp && !ndif[erpm_pkg::PIX_W] && (ndif[erpm_pkg::PIX_W-1:0] > threshold);

  assign cls_valid        = s1_valid;
  assign cls_data.cmp     = s1_cmp;
  assign cls_data.pos     = pos;
  assign cls_data.neg     = neg;
  assign cls_data.mag     = pos ? dif[erpm_pkg::PIX_W-1:0] : ndif[erpm_pkg::PIX_W-1:0];
  assign cls_data.x       = s1_x;
  assign cls_data.xd      = s1_xd;
  assign cls_data.y       = s1_y;
  assign cls_data.row_end = s1_end;

endmodule

### design/erpm_queue.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
module erpm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  erpm_pkg::cls_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output erpm_pkg::cls_t pop_data
);

  erpm_pkg::cls_t entries [erpm_pkg::QUEUE_DEPTH];

  logic [erpm_pkg::QPTR_W-1:0] wr_ptr;
  logic [erpm_pkg::QPTR_W-1:0] rd_ptr;
  logic [erpm_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign push_ready = count != erpm_pkg::QCNT_W'(erpm_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### design/erpm_back.sv
// Back end: run tracking and write command sequencing into the output register.
`timescale 1ns / 1ps
module erpm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cls_valid,
  output logic               cls_ready,
  input  erpm_pkg::cls_t     cls_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output erpm_pkg::cmd_req_t cmd_req
);

  // Run state
  logic                         ro;
  logic [erpm_pkg::PIX_W-1:0]   rpeak;
  logic [erpm_pkg::COORD_W-1:0] rcol;
  logic                         fo;
  logic [erpm_pkg::PIX_W-1:0]   fpeak;
  logic [erpm_pkg::COORD_W-1:0] fcol;

  // Run state after the comparison of the head pixel
  logic                         ro1;
  logic [erpm_pkg::PIX_W-1:0]   rpeak1;
  logic [erpm_pkg::COORD_W-1:0] rcol1;
  logic                         fo1;
  logic [erpm_pkg::PIX_W-1:0]   fpeak1;
  logic [erpm_pkg::COORD_W-1:0] fcol1;
  logic                         rbetter;
  logic                         fbetter;

  logic [erpm_pkg::SLOTS-1:0] slot_v;
  logic [erpm_pkg::SLOTS-1:0] done;
  logic [erpm_pkg::SLOTS-1:0] pending;
  logic [erpm_pkg::SLOTS-1:0] sel;
  logic                       last;
  logic                       out_load;
  logic                       advance;
  logic                       emit;
  erpm_pkg::cmd_req_t         slot_cmd [erpm_pkg::SLOTS];
  erpm_pkg::cmd_req_t         sel_cmd;
  erpm_pkg::cmd_req_t         out_cmd;

  // Run updates caused by the comparison
  assign rbetter = cls_data.mag > rpeak;
  assign fbetter = cls_data.mag > fpeak;

  always_comb begin
    ro1    = ro;
    rpeak1 = rpeak;
    rcol1  = rcol;
    fo1    = fo;
    fpeak1 = fpeak;
    fcol1  = fcol;
    if (cls_data.cmp) begin
      ro1    = cls_data.pos;
      rpeak1 = '0;
      if (cls_data.pos) begin
        rpeak1 = rbetter ? cls_data.mag : rpeak;
        if (rbetter) begin
          rcol1 = cls_data.xd;
        end
      end
      fo1    = cls_data.neg;
      fpeak1 = '0;
      if (cls_data.neg) begin
        fpeak1 = fbetter ? cls_data.mag : fpeak;
        if (fbetter) begin
          fcol1 = cls_data.x;
        end
      end
    end
  end

  // Command slots in emission order
  assign slot_v[0] = cls_data.cmp && (cls_data.pos || ro);
  assign slot_v[1] = cls_data.cmp && (cls_data.neg || fo);
  assign slot_v[2] = cls_data.row_end && ro1;
  assign slot_v[3] = cls_data.row_end && fo1;

  always_comb begin
    slot_cmd[0] = '{write_x: cls_data.pos ? cls_data.xd : rcol, write_y: cls_data.y,
                    channel_mask: cls_data.pos ? erpm_pkg::MASK_CLEAR_POS : erpm_pkg::MASK_PAINT,
                    red_value: erpm_pkg::VAL_ZERO,
                    green_value: cls_data.pos ? erpm_pkg::VAL_ZERO : erpm_pkg::VAL_FULL,
                    blue_value: erpm_pkg::VAL_ZERO, last_write: 1'b0};
    slot_cmd[1] = '{write_x: cls_data.neg ? cls_data.x : fcol, write_y: cls_data.y,
                    channel_mask: cls_data.neg ? erpm_pkg::MASK_CLEAR_NEG : erpm_pkg::MASK_PAINT,
                    red_value: cls_data.neg ? erpm_pkg::VAL_ZERO : erpm_pkg::VAL_FULL,
                    green_value: erpm_pkg::VAL_ZERO,
                    blue_value: erpm_pkg::VAL_ZERO, last_write: 1'b0};
    slot_cmd[2] = '{write_x: rcol1, write_y: cls_data.y,
                    channel_mask: erpm_pkg::MASK_PAINT,
                    red_value: erpm_pkg::VAL_ZERO, green_value: erpm_pkg::VAL_FULL,
                    blue_value: erpm_pkg::VAL_ZERO, last_write: 1'b0};
    slot_cmd[3] = '{write_x: fcol1, write_y: cls_data.y,
                    channel_mask: erpm_pkg::MASK_PAINT,
                    red_value: erpm_pkg::VAL_FULL, green_value: erpm_pkg::VAL_ZERO,
                    blue_value: erpm_pkg::VAL_ZERO, last_write: 1'b0};
  end

  // Pick the first slot still to go
  assign pending = slot_v & ~done;
  always_comb begin
    sel     = '0;
    sel_cmd = slot_cmd[0];
    for (int i = erpm_pkg::SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel     = '0;
        sel[i]  = 1'b1;
        sel_cmd = slot_cmd[i];
      end
    end
  end

  assign last      = (pending & ~sel) == '0;
  assign out_load  = !cmd_valid || cmd_ready;
  assign emit      = cls_valid && (pending != '0) && out_load;
  assign advance   = cls_valid && ((pending == '0) || (out_load && last));
  assign cls_ready = advance;

  // Selected command with its final-write flag
  always_comb begin
    out_cmd            = sel_cmd;
    out_cmd.last_write = last;
  end

  // Slot progress for the head pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (advance) begin
      done <= '0;
    end else if (emit) begin
      done <= done | sel;
    end
  end

  // Run state commits when the head pixel retires
  always_ff @(posedge clk) begin
    if (rst) begin
      ro    <= 1'b0;
      rpeak <= '0;
      rcol  <= '0;
      fo    <= 1'b0;
      fpeak <= '0;
      fcol  <= '0;
    end else if (advance) begin
      rcol <= rcol1;
      fcol <= fcol1;
      if (cls_data.row_end) begin
        ro    <= 1'b0;
        rpeak <= '0;
        fo    <= 1'b0;
        fpeak <= '0;
      end else begin
        ro    <= ro1;
        rpeak <= rpeak1;
        fo    <= fo1;
        fpeak <= fpeak1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (out_load) begin
      cmd_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_req <= out_cmd;
    end
  end

endmodule
